@@ src/cdq_pkg.sv @@
// Shared constants and types for the circular double-ended queue.
package cdq_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int DATA_W    = 32;
    localparam int FILL_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;
    localparam int MODE_W    = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 2'd3;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_DENIED    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_FULL     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IN_RESTR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUT_RESTR = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_MODE = 3'd0;

    // Outcome of one request as decided by the pointer unit.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              pop_ok;
    } t_op_res;

endpackage

@@ src/circular_double_ended_queue_top.sv @@
// Top level of the circular double-ended queue: stream ports, config port and result path.
//
// One request enters on the slave stream: tuser carries the operation (push back,
// push front, pop front, pop back) and tdata the word to push. Every request gives
// exactly one result on the master stream: tuser carries the status (done,
// overflow, underflow, not allowed in the current mode), tdata the popped word
// (zero unless a pop succeeded) and the entry count after the request.
// Head, tail and count live in flip-flops and are updated in the cycle a request
// is accepted; the words live in a RAM with a registered read. A request's result
// is registered in the read stage and then in the output register. Requests can be
// accepted every cycle, one per cycle, as long as the result side keeps up; the
// RAM read latency only adds the extra stage, not a gap between requests.
// When the receiver stalls, one result waits in the output register and one more
// in the read stage, then s_axis_tready drops until the output is taken.
// Reset empties the queue and sets the restriction mode to full deque; RAM
// contents are not cleared and need no clearing pass. The mode register sits at
// APB address 0 and should be written only while no request is in flight.
module circular_double_ended_queue_top #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // tdata: push_value[31:0]
    input  logic [31:0]                 s_axis_tdata,
    // tuser: func[1:0]
    input  logic [1:0]                  s_axis_tuser,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: pop_value[31:0], fill_count[39:32]
    output logic [39:0]                 m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cdq_pkg::PADDR_W-1:0] paddr,
    input  logic [cdq_pkg::PDATA_W-1:0] pwdata,
    output logic [cdq_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [MODE_W-1:0] r_mode;
    logic              fire, s1_adv, out_free;
    t_op_res           res;
    logic              wr_en, rd_en;
    logic [AW-1:0]     addr;
    logic [FILL_W-1:0] fill;
    logic [DATA_W-1:0] rd_data;

    logic              r_s1_valid;
    logic [STAT_W-1:0] r_s1_status;
    logic              r_s1_pop;
    logic [FILL_W-1:0] r_s1_fill;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [DATA_W-1:0] r_out_pop;
    logic [FILL_W-1:0] r_out_fill;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODE) ? PDATA_W'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FULL;
        end else if (psel && penable && pwrite && (paddr == ADDR_MODE)) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    // Read stage moves on when the output register is empty or being emptied.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign fire          = s_axis_tvalid && s_axis_tready;

    cdq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_func  (s_axis_tuser),
        .i_mode  (r_mode),
        .o_res   (res),
        .o_wr_en (wr_en),
        .o_rd_en (rd_en),
        .o_addr  (addr),
        .o_fill  (fill)
    );

    // Read data is held by the RAM while the read stage stalls, since no new
    // request (and so no new read) can be accepted then.
    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (addr),
        .i_wr_data (s_axis_tdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
        if (fire) begin
            r_s1_status <= res.status;
            r_s1_pop    <= res.pop_ok;
            r_s1_fill   <= fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_pop    <= r_s1_pop ? rd_data : '0;
            r_out_fill   <= r_s1_fill;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_fill, r_out_pop};

endmodule

@@ src/cdq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/cdq_ptr.sv @@
// Head, tail and count registers of the queue and the per-request decision logic.
module cdq_ptr #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [cdq_pkg::FUNC_W-1:0] i_func,
    input  logic [cdq_pkg::MODE_W-1:0] i_mode,
    output cdq_pkg::t_op_res           o_res,
    output logic                       o_wr_en,
    output logic                       o_rd_en,
    output logic [$clog2(DEPTH)-1:0]   o_addr,
    output logic [cdq_pkg::FILL_W-1:0] o_fill
);
    import cdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [CW+FILL_W-1:0] fill_ext;
    logic          empty, full, denied, is_push;
    logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;

    assign empty     = (r_cnt == '0);
    assign full      = (r_cnt == FULL_CNT);
    assign is_push   = (i_func == FUNC_PUSH_BACK) || (i_func == FUNC_PUSH_FRONT);
    assign denied    = ((i_mode == MODE_IN_RESTR) && (i_func == FUNC_PUSH_FRONT)) ||
                       ((i_mode == MODE_OUT_RESTR) && (i_func == FUNC_POP_BACK));
    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign head_prev = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - AW'(1);

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_cnt        = r_cnt;
        o_res.status = ST_DONE;
        o_res.pop_ok = 1'b0;
        o_wr_en      = 1'b0;
        o_rd_en      = 1'b0;
        o_addr       = '0;
        if (denied) begin
            o_res.status = ST_DENIED;
        end else if (is_push) begin
            if (full) begin
                o_res.status = ST_OVERFLOW;
            end else begin
                o_wr_en = i_fire;
                n_cnt   = r_cnt + CW'(1);
                if (empty) begin
                    // First entry always lands at index zero.
                    n_head = '0;
                    n_tail = '0;
                    o_addr = '0;
                end else if (i_func == FUNC_PUSH_BACK) begin
                    n_tail = tail_next;
                    o_addr = tail_next;
                end else begin
                    n_head = head_prev;
                    o_addr = head_prev;
                end
            end
        end else begin
            if (empty) begin
                o_res.status = ST_UNDERFLOW;
            end else begin
                o_res.pop_ok = 1'b1;
                o_rd_en      = i_fire;
                n_cnt        = r_cnt - CW'(1);
                if (i_func == FUNC_POP_FRONT) begin
                    o_addr = r_head;
                    n_head = head_next;
                end else begin
                    o_addr = r_tail;
                    n_tail = tail_prev;
                end
                if (n_cnt == '0) begin
                    n_head = '0;
                    n_tail = '0;
                end
            end
        end
    end

    // The reported count keeps only its low eight bits.
    assign fill_ext = {{FILL_W{1'b0}}, n_cnt};
    assign o_fill   = fill_ext[FILL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else if (i_fire) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ dv/circular_double_ended_queue_top_test.sv @@
// Self-checking stream testbench for the circular double-ended queue top level.
`timescale 1ns / 100ps

module circular_double_ended_queue_top_test;
    import cdq_pkg::*;

    localparam int QDEPTH         = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int DIR_ROWS       = 23;
    localparam logic [MODE_W-1:0] MODE_ALL_OPEN = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] pop_value;
        logic [FILL_W-1:0] fill_count;
    } cdq_result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] word;
        logic              typed;
        cdq_result_t       want;
    } dir_row_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic [31:0]         s_axis_tdata  = '0;
    logic [1:0]          s_axis_tuser  = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [39:0]         m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b1;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Shadow copy of the queue used for prediction.
    logic [DATA_W-1:0]   shadow_store [QDEPTH];
    int                  shadow_head  = 0;
    int                  shadow_tail  = 0;
    int                  shadow_count = 0;
    logic [MODE_W-1:0]   shadow_mode  = MODE_FULL;

    cdq_result_t         pending_results [$];
    int                  err_cnt      = 0;
    int                  quiet_cycles = 0;
    bit                  idle_on      = 1'b1;

    // Directed requests; rows with typed set carry the result read straight off the spec.
    dir_row_t dir_tab [DIR_ROWS] = '{
        '{MODE_FULL,      FUNC_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_UNDERFLOW, 32'h0, 8'd0}},
        '{MODE_FULL,      FUNC_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{ST_UNDERFLOW, 32'h0, 8'd0}},
        '{MODE_FULL,      FUNC_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{ST_DONE, 32'h0, 8'd1}},
        '{MODE_FULL,      FUNC_PUSH_FRONT, 32'h8000_0000, 1'b1, '{ST_DONE, 32'h0, 8'd2}},
        '{MODE_FULL,      FUNC_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'h0, 8'd3}},
        '{MODE_FULL,      FUNC_PUSH_FRONT, 32'h0000_0000, 1'b0, '{ST_DONE, 32'h0, 8'd0}},
        '{MODE_FULL,      FUNC_POP_BACK,   32'h0000_0000, 1'b1, '{ST_DONE, 32'hFFFF_FFFF, 8'd3}},
        '{MODE_FULL,      FUNC_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_DONE, 32'h0, 8'd2}},
        '{MODE_FULL,      FUNC_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_DONE, 32'h8000_0000, 8'd1}},
        '{MODE_FULL,      FUNC_POP_BACK,   32'h0000_0000, 1'b1, '{ST_DONE, 32'h7FFF_FFFF, 8'd0}},
        '{MODE_FULL,      FUNC_PUSH_FRONT, 32'h1357_9BDF, 1'b0, '{ST_DONE, 32'h0, 8'd0}},
        '{MODE_FULL,      FUNC_POP_BACK,   32'h0000_0000, 1'b0, '{ST_DONE, 32'h0, 8'd0}},
        '{MODE_IN_RESTR,  FUNC_PUSH_FRONT, 32'h0000_0005, 1'b1, '{ST_DENIED, 32'h0, 8'd0}},
        '{MODE_IN_RESTR,  FUNC_PUSH_BACK,  32'hA5A5_A5A5, 1'b1, '{ST_DONE, 32'h0, 8'd1}},
        '{MODE_IN_RESTR,  FUNC_POP_BACK,   32'h0000_0000, 1'b1, '{ST_DONE, 32'hA5A5_A5A5, 8'd0}},
        '{MODE_IN_RESTR,  FUNC_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_UNDERFLOW, 32'h0, 8'd0}},
        '{MODE_OUT_RESTR, FUNC_POP_BACK,   32'h0000_0000, 1'b1, '{ST_DENIED, 32'h0, 8'd0}},
        '{MODE_OUT_RESTR, FUNC_PUSH_FRONT, 32'h1234_5678, 1'b1, '{ST_DONE, 32'h0, 8'd1}},
        '{MODE_OUT_RESTR, FUNC_POP_BACK,   32'h0000_0000, 1'b1, '{ST_DENIED, 32'h0, 8'd1}},
        '{MODE_OUT_RESTR, FUNC_POP_FRONT,  32'h0000_0000, 1'b1, '{ST_DONE, 32'h1234_5678, 8'd0}},
        '{MODE_ALL_OPEN,  FUNC_PUSH_FRONT, 32'h5555_AAAA, 1'b0, '{ST_DONE, 32'h0, 8'd0}},
        '{MODE_ALL_OPEN,  FUNC_POP_BACK,   32'h0000_0000, 1'b0, '{ST_DONE, 32'h0, 8'd0}},
        '{MODE_FULL,      FUNC_PUSH_BACK,  32'hC3C3_C3C3, 1'b0, '{ST_DONE, 32'h0, 8'd0}}
    };

    circular_double_ended_queue_top #(
        .DEPTH(QDEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Applies one request to the shadow queue and returns the result it should give.
    function automatic cdq_result_t deque_apply(logic [FUNC_W-1:0] func,
                                                logic [DATA_W-1:0] word);
        cdq_result_t res;
        res = '{ST_DONE, 32'h0, 8'd0};
        if ((shadow_mode == MODE_IN_RESTR && func == FUNC_PUSH_FRONT) ||
            (shadow_mode == MODE_OUT_RESTR && func == FUNC_POP_BACK)) begin
            res.status = ST_DENIED;
        end else if (func == FUNC_PUSH_BACK || func == FUNC_PUSH_FRONT) begin
            if (shadow_count >= QDEPTH) begin
                res.status = ST_OVERFLOW;
            end else begin
                if (shadow_count == 0) begin
                    shadow_head     = 0;
                    shadow_tail     = 0;
                    shadow_store[0] = word;
                end else if (func == FUNC_PUSH_BACK) begin
                    shadow_tail = (shadow_tail == QDEPTH - 1) ? 0 : shadow_tail + 1;
                    shadow_store[shadow_tail] = word;
                end else begin
                    shadow_head = (shadow_head == 0) ? QDEPTH - 1 : shadow_head - 1;
                    shadow_store[shadow_head] = word;
                end
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                if (func == FUNC_POP_FRONT) begin
                    res.pop_value = shadow_store[shadow_head];
                    shadow_head   = (shadow_head == QDEPTH - 1) ? 0 : shadow_head + 1;
                end else begin
                    res.pop_value = shadow_store[shadow_tail];
                    shadow_tail   = (shadow_tail == 0) ? QDEPTH - 1 : shadow_tail - 1;
                end
                shadow_count--;
                if (shadow_count == 0) begin
                    shadow_head = 0;
                    shadow_tail = 0;
                end
            end
        end
        res.fill_count = shadow_count[FILL_W-1:0];
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic flag_error(string what, cdq_result_t want, cdq_result_t got);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t: %s: expected status %0d pop 0x%08h fill %0d,",
                     $realtime, what, want.status, want.pop_value, want.fill_count,
                     " got status %0d pop 0x%08h fill %0d",
                     got.status, got.pop_value, got.fill_count);
        end
    endtask

    // Sends one request; tvalid stays high on return so back-to-back transfers need no gap.
    task automatic send_req(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] word,
                            logic typed, cdq_result_t typed_want);
        int          gap;
        cdq_result_t predicted;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = deque_apply(func, word);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    // Waits for the queue of results to empty, then writes and reads back the mode.
    task automatic cfg_mode(logic [MODE_W-1:0] mode);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODE;
        pwdata  <= PDATA_W'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== PDATA_W'(mode)) begin
            err_cnt++;
            if (err_cnt <= 10) begin
                $display("%0t: mode readback: expected %0d, got 0x%08h", $realtime, mode, prdata);
            end
        end
        psel        <= 1'b0;
        penable     <= 1'b0;
        shadow_mode  = mode;
    endtask

    task automatic run_phase(logic [MODE_W-1:0] mode, int n_items, int push_pct);
        logic [FUNC_W-1:0] func;
        int                k;
        cfg_mode(mode);
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                func = FUNC_W'($urandom_range(0, 3));
            end else if ($urandom_range(1, 100) <= push_pct) begin
                func = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
            end else begin
                func = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
            end
            send_req(func, pick_word(), 1'b0, '0);
        end
    endtask

    // Receiver: random stalls while idling is enabled.
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        cdq_result_t got;
        cdq_result_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32]};
            if (pending_results.size() == 0) begin
                flag_error("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.pop_value !== want.pop_value ||
                    got.fill_count !== want.fill_count) begin
                    flag_error("result mismatch", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("circular_double_ended_queue_top_test: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int k;
        foreach (shadow_store[i]) shadow_store[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_mode(MODE_FULL);
        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].mode != shadow_mode) cfg_mode(dir_tab[r].mode);
            send_req(dir_tab[r].func, dir_tab[r].word, dir_tab[r].typed, dir_tab[r].want);
        end

        // Fill past capacity from both ends so the indices wrap and overflow is hit.
        cfg_mode(MODE_FULL);
        for (k = 0; k < QDEPTH + 2; k++) begin
            send_req($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK, pick_word(),
                     1'b0, '0);
        end
        // The mode check wins over a full queue.
        cfg_mode(MODE_IN_RESTR);
        send_req(FUNC_PUSH_FRONT, pick_word(), 1'b0, '0);
        send_req(FUNC_PUSH_BACK, pick_word(), 1'b0, '0);
        cfg_mode(MODE_OUT_RESTR);
        send_req(FUNC_POP_BACK, pick_word(), 1'b0, '0);
        send_req(FUNC_POP_FRONT, pick_word(), 1'b0, '0);
        send_req(FUNC_PUSH_BACK, pick_word(), 1'b0, '0);
        send_req(FUNC_PUSH_BACK, pick_word(), 1'b0, '0);

        run_phase(MODE_OUT_RESTR, 150, 15);
        run_phase(MODE_ALL_OPEN, 150, 85);
        run_phase(MODE_IN_RESTR, 150, 50);
        run_phase(MODE_FULL, 150, 15);
        idle_on = 1'b0;
        run_phase(MODE_FULL, 150, 50);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("circular_double_ended_queue_top_test: PASS");
        end else begin
            $display("circular_double_ended_queue_top_test: FAIL");
        end
        $finish;
    end

endmodule
